// ===== design/rcs_pkg.sv =====
// Package for the RIFF chunk scanner: record type, scan constants and
// id character checks. Used by every module of the block; no dependencies.
package rcs_pkg;

  localparam int unsigned HdrBytes   = 12;
  localparam int unsigned WinBytes   = 8;
  localparam int unsigned RecQDepth  = 4;

  localparam logic [31:0] NullCode   = 32'h4E55_4C4C;

  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDigitLo   = 8'h30;
  localparam logic [7:0] ChDigitHi   = 8'h39;
  localparam logic [7:0] ChUpperLo   = 8'h41;
  localparam logic [7:0] ChUpperHi   = 8'h5A;
  localparam logic [7:0] ChLowerLo   = 8'h61;
  localparam logic [7:0] ChLowerHi   = 8'h7A;
  localparam logic [7:0] ChZero      = 8'h00;

  // Chunk id "data", first byte first.
  localparam logic [31:0] DataCode   = 32'h6461_7461;

  localparam logic RecChunk = 1'b0;
  localparam logic RecJunk  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] code;
    logic [31:0] length;
    logic [31:0] start;
    logic        cleared;
    logic        last;
  } rcs_rec_t;

  function automatic logic id_first_ok(input logic [7:0] c);
    return (c >= ChDigitLo && c <= ChDigitHi) ||
           (c >= ChUpperLo && c <= ChUpperHi) ||
           (c >= ChLowerLo && c <= ChLowerHi);
  endfunction

  function automatic logic id_rest_ok(input logic [7:0] c);
    return (c == ChSpace) || id_first_ok(c);
  endfunction

endpackage

// ===== design/rcs_core.sv =====
// Scan core of the RIFF chunk scanner: header window, offset, body skip and
// junk run state, plus the per-byte judgement. Depends on rcs_pkg.
module rcs_core import rcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] file_length_i,
  output logic [1:0]  rec_cnt_o,
  output rcs_rec_t    rec0_o,
  output rcs_rec_t    rec1_o
);

  localparam logic [2:0] FillFull = 3'(WinBytes - 1);

  logic [7:0]  win_q [WinBytes-1];
  logic [7:0]  win_d [WinBytes-1];
  logic [2:0]  fill_q, fill_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] skip_q, skip_d;
  logic        pad_q, pad_d;
  logic [31:0] jc_q, jc_d;
  logic [31:0] js_q, js_d;

  logic        active, past_hdr, consume, scan, full, last;
  logic [31:0] rem, pos_inc, size, size_eff, code, jc_new, js_new;
  logic        is_data, id_ok, size_fits, cleared, ok, fail, end_add, junk_emit;
  logic [2:0]  fill_after;
  logic [3:0]  add_n;
  rcs_rec_t    junk_rec, chunk_rec;

  always_comb begin
    active   = pos_q < file_length_i;
    pos_inc  = pos_q + 32'd1;
    rem      = file_length_i - pos_inc;
    last     = (rem == 32'd0);
    past_hdr = step_i && active && (pos_q >= 32'(HdrBytes));
    consume  = past_hdr && (skip_q == 32'd0);
    // A zero pad byte after an odd body is swallowed; anything else is scanned.
    scan     = consume && !(pad_q && byte_i == ChZero);
    full     = (fill_q == FillFull);

    size      = {byte_i, win_q[6], win_q[5], win_q[4]};
    code      = {win_q[0], win_q[1], win_q[2], win_q[3]};
    is_data   = (code == DataCode);
    id_ok     = id_first_ok(win_q[0]) && id_rest_ok(win_q[1]) &&
                id_rest_ok(win_q[2]) && id_rest_ok(win_q[3]);
    // Bytes left from the window start are rem plus the eight window bytes.
    size_fits = ({1'b0, size} <= ({1'b0, rem} + 33'd8));
    ok        = scan && full && id_ok && (is_data || size_fits);
    fail      = scan && full && !ok;
    cleared   = is_data && (size > rem);
    size_eff  = cleared ? 32'd0 : size;

    if (full) begin
      fill_after = ok ? 3'd0 : FillFull;
    end else begin
      fill_after = fill_q + 3'd1;
    end
    end_add = scan && last && (fill_after != 3'd0);

    add_n  = {3'd0, fail} + (end_add ? {1'b0, fill_after} : 4'd0);
    jc_new = jc_q + {28'd0, add_n};
    // A new run starts at the oldest byte held in the window.
    js_new = (jc_q == 32'd0) ? (pos_q - {29'd0, fill_q}) : js_q;
    junk_emit = (ok && jc_q != 32'd0) || end_add;

    junk_rec.kind    = RecJunk;
    junk_rec.code    = NullCode;
    junk_rec.length  = jc_new;
    junk_rec.start   = js_new;
    junk_rec.cleared = 1'b0;
    junk_rec.last    = !ok;

    chunk_rec.kind    = RecChunk;
    chunk_rec.code    = code;
    chunk_rec.length  = size_eff;
    chunk_rec.start   = pos_inc;
    chunk_rec.cleared = cleared;
    chunk_rec.last    = 1'b1;

    rec_cnt_o = {1'b0, junk_emit} + {1'b0, ok};
    rec0_o    = junk_emit ? junk_rec : chunk_rec;
    rec1_o    = chunk_rec;

    pos_d = (step_i && active) ? pos_inc : pos_q;

    skip_d = skip_q;
    if (ok) begin
      skip_d = size_eff;
    end else if (past_hdr && skip_q != 32'd0) begin
      skip_d = skip_q - 32'd1;
    end

    pad_d = pad_q;
    if (ok) begin
      pad_d = size_eff[0];
    end else if (consume) begin
      pad_d = 1'b0;
    end

    fill_d = fill_q;
    jc_d   = jc_q;
    js_d   = js_q;
    if (scan) begin
      fill_d = end_add ? 3'd0 : fill_after;
      jc_d   = (ok || end_add) ? 32'd0 : jc_new;
      js_d   = js_new;
    end

    for (int i = 0; i < WinBytes - 1; i++) begin
      win_d[i] = win_q[i];
    end
    if (fail) begin
      for (int i = 0; i < WinBytes - 2; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WinBytes-2] = byte_i;
    end else if (scan && !full) begin
      win_d[fill_q] = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 3'd0;
      pos_q  <= 32'd0;
      skip_q <= 32'd0;
      pad_q  <= 1'b0;
      jc_q   <= 32'd0;
      js_q   <= 32'd0;
    end else begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      skip_q <= skip_d;
      pad_q  <= pad_d;
      jc_q   <= jc_d;
      js_q   <= js_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== design/rcs_rec_fifo.sv =====
// Result queue of the RIFF chunk scanner: takes up to two records a cycle
// and hands out one per request. Depends on rcs_pkg.
module rcs_rec_fifo import rcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  push_cnt_i,
  input  rcs_rec_t    push0_i,
  input  rcs_rec_t    push1_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rcs_rec_t    out_rec_o
);

  localparam int unsigned PtrW = $clog2(RecQDepth);
  localparam int unsigned CntW = $clog2(RecQDepth + 1);

  rcs_rec_t        mem_q [RecQDepth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  always_comb begin
    pop         = out_valid_o && out_ready_i;
    wp_d        = wp_q + PtrW'(push_cnt_i);
    rp_d        = pop ? rp_q + PtrW'(1) : rp_q;
    cnt_d       = cnt_q + CntW'(push_cnt_i) - CntW'(pop);
    // Two free slots are needed since one byte can produce two records.
    room_o      = (cnt_q <= CntW'(RecQDepth - 2));
    out_valid_o = (cnt_q != '0);
    out_rec_o   = mem_q[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wp_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wp_q + PtrW'(1)] <= push1_i;
    end
  end

endmodule

// ===== design/riff_chunk_scanner.sv =====
// RIFF chunk scanner top level: input register, configuration register,
// scan core and result queue. Depends on rcs_pkg, rcs_core, rcs_rec_fifo.
//
// Usage: write the file length on the cfg channel (cfg_file_length_i with
// cfg_valid_i; cfg_ready_o is always high), then stream the file bytes from
// offset zero on the input channel, one request per byte. Each chunk header
// found gives a chunk record; runs of bytes that do not form a header give
// junk records with code NULL, emitted before the next chunk record and at
// the end of the file. One byte gives zero, one or two records; last_of_run
// marks the final record of a byte. Bytes past the file length are taken
// and ignored.
// Path: an accepted byte is held in the input register and is scanned when
// the queue has room; its records are registered into the result queue and
// are then valid on the output. Throughput: one byte per cycle while the output
// is taken; the rate is bounded only by the four-entry result queue, which must
// hold two free slots before the registered byte is scanned.
// Reset clears the file length, offset, window fill count and junk state and empties
// the queue. When the receiver stalls, records wait in the queue and the
// input register holds one byte, after which in_ready_o drops.
module riff_chunk_scanner import rcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_file_length_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        record_kind_o,
  output logic [31:0] chunk_code_o,
  output logic [31:0] chunk_length_o,
  output logic [31:0] start_offset_o,
  output logic        size_cleared_o,
  output logic        last_of_run_o
);

  logic [31:0] file_length_q;
  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        room, step;
  logic [1:0]  rec_cnt;
  rcs_rec_t    rec0, rec1, out_rec;

  assign cfg_ready_o = 1'b1;
  assign step        = in_vld_q && room;
  assign in_ready_o  = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= 32'd0;
      in_vld_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        file_length_q <= cfg_file_length_i;
      end
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  rcs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (byte_q),
    .file_length_i (file_length_q),
    .rec_cnt_o     (rec_cnt),
    .rec0_o        (rec0),
    .rec1_o        (rec1)
  );

  rcs_rec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (rec_cnt),
    .push0_i     (rec0),
    .push1_i     (rec1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rec_o   (out_rec)
  );

  assign record_kind_o  = out_rec.kind;
  assign chunk_code_o   = out_rec.code;
  assign chunk_length_o = out_rec.length;
  assign start_offset_o = out_rec.start;
  assign size_cleared_o = out_rec.cleared;
  assign last_of_run_o  = out_rec.last;

endmodule
